[hw/rtl/md5_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 package
// Types, constants and per-step tables shared by the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PAD  = 5'b00010,
        S_FILL = 5'b00100,
        S_COMP = 5'b01000,
        S_DONE = 5'b10000
    } md5_state_t;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0]  PAD_BYTE  = 8'h80;
    localparam logic [60:0] COUNT_MAX = '1;
    localparam logic [3:0]  LEN_LO_WORD = 4'd14;
    localparam logic [3:0]  LEN_HI_WORD = 4'd15;

    function automatic logic [31:0] md5_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] idx);
        logic [4:0] s;
        case ({idx[5:4], idx[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] md5_msg_index(input logic [5:0] idx);
        logic [3:0] g;
        case (idx[5:4])
            2'd0:    g = idx[3:0];
            2'd1:    g = idx[3:0] * 4'd5 + 4'd1;
            2'd2:    g = idx[3:0] * 4'd3 + 4'd5;
            default: g = idx[3:0] * 4'd7;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] md5_f(input logic [1:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (rnd)
            2'd0:    f = d ^ (b & (c ^ d));
            2'd1:    f = c ^ (d & (b ^ c));
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic logic [31:0] md5_bswap(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage
`default_nettype wire

[hw/rtl/md5_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 channel interfaces
// Valid/ready channels for message bytes in and digests out.
// ----------------------------------------------------------------------------
interface md5_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_byte;

    modport source (output valid, output data_byte, output byte_valid,
                    output last_byte, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input last_byte, output ready);
endinterface

interface md5_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_first_half;
    logic [63:0] digest_second_half;

    modport source (output valid, output digest_first_half,
                    output digest_second_half, input ready);
    modport sink   (input valid, input digest_first_half,
                    input digest_second_half, output ready);
endinterface
`default_nettype wire

[hw/rtl/md5_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module md5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/md5_message_digest.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// MD5 message digest
// Byte-stream MD5: buffers 64-byte blocks in a RAM and compresses them with
// one round per cycle.
// ----------------------------------------------------------------------------
// A byte item is taken while the block is idle. The item that completes a
// 64-byte block holds off input while the single round unit runs the 64
// steps out of the block RAM (one registered read per step) and folds the
// result into the chaining words. A closing item fills the remaining buffer
// words with padding and the length, then costs one compression, or two
// when fewer than nine bytes of room are left; the digest then sits in an
// output register, so the next message may start while it waits to be taken.
// ----------------------------------------------------------------------------
module md5_message_digest
    import md5_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    md5_in_if.sink      msg,
    md5_out_if.source   digest
);

    md5_state_t  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] count_reg, count_next;
    logic [31:0] acc_reg, acc_next;
    logic [3:0]  wp_reg, wp_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        closing_reg, closing_next;
    logic        pad_pend_reg, pad_pend_next;
    logic        extra_reg, extra_next;
    logic [31:0] ch_a_reg, ch_a_next, ch_b_reg, ch_b_next;
    logic [31:0] ch_c_reg, ch_c_next, ch_d_reg, ch_d_next;
    logic [31:0] wa_reg, wa_next, wb_reg, wb_next;
    logic [31:0] wc_reg, wc_next, wd_reg, wd_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] dig_hi_reg, dig_hi_next, dig_lo_reg, dig_lo_next;

    logic        ram_we;
    logic [3:0]  ram_waddr, ram_raddr;
    logic [31:0] ram_wdata, ram_rdata;

    logic [1:0]  lane;
    logic [31:0] lane_base;
    logic [31:0] byte_word, pad_word;
    logic [5:0]  step;
    logic [31:0] sum, rot;
    logic [63:0] rot_wide;
    logic [31:0] len_lo, len_hi;

    md5_ram #(
        .WIDTH (32),
        .DEPTH (16)
    ) u_block_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign msg.ready                 = (state_reg == S_IDLE);
    assign digest.valid              = out_valid_reg;
    assign digest.digest_first_half  = dig_hi_reg;
    assign digest.digest_second_half = dig_lo_reg;

    assign lane      = fill_reg[1:0];
    assign lane_base = (lane == 2'd0) ? 32'h0 : acc_reg;
    assign byte_word = lane_base | ({24'h0, msg.data_byte} << {lane, 3'b000});
    assign pad_word  = lane_base | ({24'h0, PAD_BYTE} << {lane, 3'b000});
    assign len_lo    = {count_reg[28:0], 3'b000};
    assign len_hi    = count_reg[60:29];

    // round pipeline: read issued for step cnt, round done for step cnt-1
    assign step     = cnt_reg[5:0] - 6'd1;
    assign sum      = wa_reg + md5_f(step[5:4], wb_reg, wc_reg, wd_reg) + md5_k(step)
                      + ram_rdata;
    assign rot_wide = {sum, sum} << md5_s(step);
    assign rot      = rot_wide[63:32];

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        wp_next        = wp_reg;
        cnt_next       = cnt_reg;
        closing_next   = closing_reg;
        pad_pend_next  = pad_pend_reg;
        extra_next     = extra_reg;
        ch_a_next      = ch_a_reg;
        ch_b_next      = ch_b_reg;
        ch_c_next      = ch_c_reg;
        ch_d_next      = ch_d_reg;
        wa_next        = wa_reg;
        wb_next        = wb_reg;
        wc_next        = wc_reg;
        wd_next        = wd_reg;
        out_valid_next = out_valid_reg;
        dig_hi_next    = dig_hi_reg;
        dig_lo_next    = dig_lo_reg;
        ram_we         = 1'b0;
        ram_waddr      = fill_reg[5:2];
        ram_wdata      = byte_word;
        ram_raddr      = md5_msg_index(cnt_reg[5:0]);

        if (out_valid_reg && digest.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (msg.valid)
                begin
                    if (msg.byte_valid)
                    begin
                        acc_next  = byte_word;
                        fill_next = fill_reg + 6'd1;
                        if (count_reg != COUNT_MAX)
                        begin
                            count_next = count_reg + 61'd1;
                        end
                        if (lane == 2'd3)
                        begin
                            ram_we = 1'b1;
                        end
                        if (fill_reg == 6'd63)
                        begin
                            state_next    = S_COMP;
                            cnt_next      = 7'd0;
                            pad_pend_next = msg.last_byte;
                            closing_next  = msg.last_byte;
                        end
                        else if (msg.last_byte)
                        begin
                            closing_next = 1'b1;
                            state_next   = S_PAD;
                        end
                    end
                    else if (msg.last_byte)
                    begin
                        closing_next = 1'b1;
                        state_next   = S_PAD;
                    end
                end
            end

            S_PAD:
            begin
                ram_we     = 1'b1;
                ram_wdata  = pad_word;
                extra_next = (fill_reg[5:3] == 3'b111);
                wp_next    = fill_reg[5:2] + 4'd1;
                if (fill_reg[5:2] == 4'd15)
                begin
                    state_next = S_COMP;
                    cnt_next   = 7'd0;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end

            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = wp_reg;
                if (!extra_reg && wp_reg == LEN_LO_WORD)
                begin
                    ram_wdata = len_lo;
                end
                else if (!extra_reg && wp_reg == LEN_HI_WORD)
                begin
                    ram_wdata = len_hi;
                end
                else
                begin
                    ram_wdata = 32'h0;
                end
                wp_next = wp_reg + 4'd1;
                if (wp_reg == 4'd15)
                begin
                    state_next = S_COMP;
                    cnt_next   = 7'd0;
                end
            end

            S_COMP:
            begin
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    wa_next = ch_a_reg;
                    wb_next = ch_b_reg;
                    wc_next = ch_c_reg;
                    wd_next = ch_d_reg;
                end
                else if (cnt_reg <= 7'd64)
                begin
                    wa_next = wd_reg;
                    wb_next = wb_reg + rot;
                    wc_next = wb_reg;
                    wd_next = wc_reg;
                end
                else
                begin
                    ch_a_next = ch_a_reg + wa_reg;
                    ch_b_next = ch_b_reg + wb_reg;
                    ch_c_next = ch_c_reg + wc_reg;
                    ch_d_next = ch_d_reg + wd_reg;
                    if (pad_pend_reg)
                    begin
                        pad_pend_next = 1'b0;
                        state_next    = S_PAD;
                    end
                    else if (extra_reg)
                    begin
                        extra_next = 1'b0;
                        wp_next    = 4'd0;
                        state_next = S_FILL;
                    end
                    else if (closing_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || digest.ready)
                begin
                    out_valid_next = 1'b1;
                    dig_hi_next    = {md5_bswap(ch_a_reg), md5_bswap(ch_b_reg)};
                    dig_lo_next    = {md5_bswap(ch_c_reg), md5_bswap(ch_d_reg)};
                    ch_a_next      = INIT_A;
                    ch_b_next      = INIT_B;
                    ch_c_next      = INIT_C;
                    ch_d_next      = INIT_D;
                    fill_next      = 6'd0;
                    count_next     = 61'd0;
                    closing_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= 6'd0;
            count_reg     <= 61'd0;
            wp_reg        <= 4'd0;
            cnt_reg       <= 7'd0;
            closing_reg   <= 1'b0;
            pad_pend_reg  <= 1'b0;
            extra_reg     <= 1'b0;
            ch_a_reg      <= INIT_A;
            ch_b_reg      <= INIT_B;
            ch_c_reg      <= INIT_C;
            ch_d_reg      <= INIT_D;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            closing_reg   <= closing_next;
            pad_pend_reg  <= pad_pend_next;
            extra_reg     <= extra_next;
            ch_a_reg      <= ch_a_next;
            ch_b_reg      <= ch_b_next;
            ch_c_reg      <= ch_c_next;
            ch_d_reg      <= ch_d_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        wa_reg     <= wa_next;
        wb_reg     <= wb_next;
        wc_reg     <= wc_next;
        wd_reg     <= wd_next;
        dig_hi_reg <= dig_hi_next;
        dig_lo_reg <= dig_lo_next;
    end

endmodule
`default_nettype wire
